[rtl/tbrf_pkg.sv]
// Package for the trapped-ball region fill block.
// Holds image geometry, label limits and request codes; no dependencies.
package tbrf_pkg;
  localparam int IMG_W     = 64;
  localparam int IMG_H     = 64;
  localparam int PIX_N     = IMG_W * IMG_H;
  localparam int COORD_W   = $clog2(IMG_W);
  localparam int ADDR_W    = $clog2(PIX_N);
  localparam int SP_W      = ADDR_W + 1;
  localparam int LABEL_W   = 13;
  localparam int MAX_R     = 8;
  localparam int LABEL_LIM = 8191;
  localparam int WALK_STEP = 2;

  localparam logic [1:0] REQ_LOAD = 2'd0;
  localparam logic [1:0] REQ_RUN  = 2'd1;
  localparam logic [1:0] REQ_READ = 2'd2;
  localparam logic [1:0] REQ_NOP  = 2'd3;

  localparam logic [1:0] CFG_RADIUS = 2'd0;
  localparam logic [1:0] CFG_WIDTH  = 2'd1;
  localparam logic [1:0] CFG_HEIGHT = 2'd2;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [2:0]         d;
  } frame_t;
endpackage

[rtl/trapped_ball_region_fill.sv]
// Trapped-ball region fill: pixel/label memory, walk stack memory and sequencer.
// Depends on tbrf_pkg. A load result is registered directly; a read passes through the
// memory read and S_RDWAIT. One item at a time: no request is taken while a result waits.
// Run: each scanned pixel is read, checked, then advanced; per disk square, disk cells
// are read and checked, others skipped, then written; its length depends on the image.
// Synchronous active-low reset clears control state; memories are not cleared.
module trapped_ball_region_fill (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_req_type,
  input  logic [11:0] in_pixel_addr,
  input  logic [7:0]  in_pixel_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [12:0] out_region_label,
  output logic        out_is_barrier,
  output logic [12:0] out_region_count,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [6:0]  cfg_data
);
  localparam int CW = tbrf_pkg::COORD_W;
  localparam int AW = tbrf_pkg::ADDR_W;
  localparam int SW = tbrf_pkg::SP_W;
  localparam int LW = tbrf_pkg::LABEL_W;

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_RDWAIT  = 4'd1;
  localparam logic [3:0] S_SCANRD  = 4'd2;
  localparam logic [3:0] S_SCANCHK = 4'd3;
  localparam logic [3:0] S_TRY     = 4'd4;
  localparam logic [3:0] S_CELL    = 4'd5;
  localparam logic [3:0] S_CELLCHK = 4'd6;
  localparam logic [3:0] S_FILL    = 4'd7;
  localparam logic [3:0] S_TRYEND  = 4'd8;
  localparam logic [3:0] S_WALK    = 4'd9;
  localparam logic [3:0] S_POPWAIT = 4'd10;
  localparam logic [3:0] S_ADV     = 4'd11;
  localparam logic [3:0] S_DONE    = 4'd12;

  logic [LW:0] pix_mem [tbrf_pkg::PIX_N];
  tbrf_pkg::frame_t stk_mem [tbrf_pkg::PIX_N];

  logic [3:0] state_r, state_nxt;
  logic [3:0] radius_r;
  logic [6:0] width_r, height_r;
  logic [LW-1:0] next_label_r, next_label_nxt;
  logic [SW-1:0] sp_r, sp_nxt;
  tbrf_pkg::frame_t top_r, top_nxt;
  logic [CW-1:0] x_r, x_nxt, y_r, y_nxt;
  logic signed [8:0] cx_r, cx_nxt, cy_r, cy_nxt;
  logic signed [4:0] dx_r, dx_nxt, dy_r, dy_nxt;
  logic fresh_r, fresh_nxt, ok_r, ok_nxt, is_top_r, is_top_nxt;
  logic out_valid_r, out_valid_nxt, out_bar_r, out_bar_nxt;
  logic [LW-1:0] out_label_r, out_label_nxt;

  logic pix_we, pix_re;
  logic [AW-1:0] pix_waddr, pix_raddr;
  logic [LW:0] pix_wdata, pix_q;
  logic stk_we, stk_re;
  logic [AW-1:0] stk_waddr, stk_raddr;
  tbrf_pkg::frame_t stk_wdata, stk_q;

  logic [3:0] r_eff;
  logic [6:0] aw_eff, ah_eff;
  logic signed [8:0] rs, row, col;
  logic signed [4:0] r5;
  logic [4:0] dxa, dya;
  logic [7:0] dist2, lim;
  logic in_disk, last_cell;
  logic [AW-1:0] cell_addr;
  logic [SW-1:0] sp_dec;

  assign r_eff  = (radius_r > 4'(tbrf_pkg::MAX_R)) ? 4'(tbrf_pkg::MAX_R) : radius_r;
  assign aw_eff = (width_r > 7'(tbrf_pkg::IMG_W)) ? 7'(tbrf_pkg::IMG_W) : width_r;
  assign ah_eff = (height_r > 7'(tbrf_pkg::IMG_H)) ? 7'(tbrf_pkg::IMG_H) : height_r;
  assign rs  = signed'({5'd0, r_eff});
  assign r5  = signed'({1'b0, r_eff});
  assign dxa = dx_r[4] ? 5'(-dx_r) : dx_r;
  assign dya = dy_r[4] ? 5'(-dy_r) : dy_r;
  assign dist2 = 8'(dxa * dxa) + 8'(dya * dya);
  assign lim   = 8'(({4'd0, r_eff} + 8'd1) * ({4'd0, r_eff} + 8'd1));
  assign in_disk = dist2 < lim;
  assign last_cell = (dx_r == r5) && (dy_r == r5);
  assign row = cy_r + 9'(dy_r);
  assign col = cx_r + 9'(dx_r);
  assign cell_addr = {row[CW-1:0], col[CW-1:0]};
  assign sp_dec = sp_r - SW'(1);

  assign in_ready = (state_r == S_IDLE) && !out_valid_r;
  assign out_valid = out_valid_r;
  assign out_region_label = out_label_r;
  assign out_is_barrier = out_bar_r;
  assign out_region_count = next_label_r - LW'(1);

  always_ff @(posedge clk) begin
    if (pix_we) pix_mem[pix_waddr] <= pix_wdata;
    if (pix_re) pix_q <= pix_mem[pix_raddr];
    if (stk_we) stk_mem[stk_waddr] <= stk_wdata;
    if (stk_re) stk_q <= stk_mem[stk_raddr];
  end

  always_comb begin
    state_nxt = state_r;
    next_label_nxt = next_label_r;
    sp_nxt = sp_r;
    top_nxt = top_r;
    x_nxt = x_r;
    y_nxt = y_r;
    cx_nxt = cx_r;
    cy_nxt = cy_r;
    dx_nxt = dx_r;
    dy_nxt = dy_r;
    fresh_nxt = fresh_r;
    ok_nxt = ok_r;
    is_top_nxt = is_top_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_label_nxt = out_label_r;
    out_bar_nxt = out_bar_r;
    pix_we = 1'b0;
    pix_re = 1'b0;
    pix_waddr = cell_addr;
    pix_raddr = cell_addr;
    pix_wdata = {1'b0, next_label_r};
    stk_we = 1'b0;
    stk_re = 1'b0;
    stk_waddr = sp_dec[AW-1:0];
    stk_raddr = sp_dec[AW-1:0];
    stk_wdata = top_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          out_label_nxt = '0;
          out_bar_nxt = 1'b0;
          pix_raddr = in_pixel_addr;
          pix_waddr = in_pixel_addr;
          case (in_req_type)
            tbrf_pkg::REQ_LOAD: begin
              pix_we = 1'b1;
              pix_wdata = {in_pixel_value != 8'd0, LW'(0)};
              out_valid_nxt = 1'b1;
            end
            tbrf_pkg::REQ_RUN: begin
              x_nxt = '0;
              y_nxt = '0;
              if (r_eff < 4'd2 || aw_eff == 7'd0 || ah_eff == 7'd0) state_nxt = S_DONE;
              else state_nxt = S_SCANRD;
            end
            tbrf_pkg::REQ_READ: begin
              pix_re = 1'b1;
              state_nxt = S_RDWAIT;
            end
            default: out_valid_nxt = 1'b1;
          endcase
        end
      end
      S_RDWAIT: begin
        out_bar_nxt = pix_q[LW];
        out_label_nxt = pix_q[LW] ? LW'(0) : pix_q[LW-1:0];
        out_valid_nxt = 1'b1;
        state_nxt = S_IDLE;
      end
      S_SCANRD: begin
        pix_re = 1'b1;
        pix_raddr = {y_r, x_r};
        state_nxt = S_SCANCHK;
      end
      S_SCANCHK: begin
        if (pix_q[LW] || pix_q[LW-1:0] != '0) state_nxt = S_ADV;
        else if (next_label_r >= LW'(tbrf_pkg::LABEL_LIM)) state_nxt = S_DONE;
        else begin
          cx_nxt = signed'({3'd0, x_r});
          cy_nxt = signed'({3'd0, y_r});
          is_top_nxt = 1'b1;
          state_nxt = S_TRY;
        end
      end
      S_TRY: begin
        dx_nxt = -r5;
        dy_nxt = -r5;
        fresh_nxt = 1'b0;
        ok_nxt = 1'b0;
        if (cx_r - rs < 0 || cy_r - rs < 0 || cx_r + rs >= signed'({2'd0, aw_eff})
            || cy_r + rs >= signed'({2'd0, ah_eff})) state_nxt = S_TRYEND;
        else state_nxt = S_CELL;
      end
      S_CELL: begin
        if (in_disk) begin
          pix_re = 1'b1;
          state_nxt = S_CELLCHK;
        end else if (last_cell) begin
          dx_nxt = -r5;
          dy_nxt = -r5;
          state_nxt = fresh_r ? S_FILL : S_TRYEND;
        end else if (dx_r == r5) begin
          dx_nxt = -r5;
          dy_nxt = dy_r + 5'sd1;
        end else dx_nxt = dx_r + 5'sd1;
      end
      S_CELLCHK: begin
        if (pix_q[LW] || (pix_q[LW-1:0] != '0 && pix_q[LW-1:0] != next_label_r))
          state_nxt = S_TRYEND;
        else begin
          if (pix_q[LW-1:0] == '0) fresh_nxt = 1'b1;
          state_nxt = S_CELL;
          if (last_cell) begin
            dx_nxt = -r5;
            dy_nxt = -r5;
            state_nxt = (fresh_r || pix_q[LW-1:0] == '0) ? S_FILL : S_TRYEND;
          end else if (dx_r == r5) begin
            dx_nxt = -r5;
            dy_nxt = dy_r + 5'sd1;
          end else dx_nxt = dx_r + 5'sd1;
        end
      end
      S_FILL: begin
        pix_we = in_disk;
        if (last_cell) begin
          ok_nxt = 1'b1;
          state_nxt = S_TRYEND;
        end else if (dx_r == r5) begin
          dx_nxt = -r5;
          dy_nxt = dy_r + 5'sd1;
        end else dx_nxt = dx_r + 5'sd1;
      end
      S_TRYEND: begin
        if (is_top_r) begin
          if (ok_r) begin
            top_nxt = '{x: x_r, y: y_r, d: 3'd0};
            sp_nxt = SW'(1);
            state_nxt = S_WALK;
          end else state_nxt = S_ADV;
        end else begin
          if (ok_r && sp_r < SW'(tbrf_pkg::PIX_N)) begin
            stk_we = 1'b1;
            top_nxt = '{x: cx_r[CW-1:0], y: cy_r[CW-1:0], d: 3'd0};
            sp_nxt = sp_r + SW'(1);
          end
          state_nxt = S_WALK;
        end
      end
      S_WALK: begin
        if (sp_r == '0) begin
          next_label_nxt = next_label_r + LW'(1);
          state_nxt = S_ADV;
        end else if (top_r.d >= 3'd4) begin
          sp_nxt = sp_dec;
          if (sp_dec != '0) begin
            stk_re = 1'b1;
            stk_raddr = AW'(sp_dec - SW'(1));
            state_nxt = S_POPWAIT;
          end
        end else begin
          top_nxt.d = top_r.d + 3'd1;
          cx_nxt = signed'({3'd0, top_r.x});
          cy_nxt = signed'({3'd0, top_r.y});
          case (top_r.d)
            3'd0: cx_nxt = signed'({3'd0, top_r.x}) + 9'(tbrf_pkg::WALK_STEP);
            3'd1: cx_nxt = signed'({3'd0, top_r.x}) - 9'(tbrf_pkg::WALK_STEP);
            3'd2: cy_nxt = signed'({3'd0, top_r.y}) + 9'(tbrf_pkg::WALK_STEP);
            default: cy_nxt = signed'({3'd0, top_r.y}) - 9'(tbrf_pkg::WALK_STEP);
          endcase
          is_top_nxt = 1'b0;
          state_nxt = S_TRY;
        end
      end
      S_POPWAIT: begin
        top_nxt = stk_q;
        state_nxt = S_WALK;
      end
      S_ADV: begin
        state_nxt = S_SCANRD;
        if (7'(x_r) + 7'd1 == aw_eff) begin
          x_nxt = '0;
          y_nxt = y_r + CW'(1);
          if (7'(y_r) + 7'd1 == ah_eff) state_nxt = S_DONE;
        end else x_nxt = x_r + CW'(1);
      end
      S_DONE: begin
        out_label_nxt = '0;
        out_bar_nxt = 1'b0;
        out_valid_nxt = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      radius_r <= 4'd4;
      width_r <= 7'd64;
      height_r <= 7'd64;
      next_label_r <= LW'(1);
      sp_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      next_label_r <= next_label_nxt;
      sp_r <= sp_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          tbrf_pkg::CFG_RADIUS: radius_r <= cfg_data[3:0];
          tbrf_pkg::CFG_WIDTH:  width_r <= cfg_data;
          tbrf_pkg::CFG_HEIGHT: height_r <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    top_r <= top_nxt;
    x_r <= x_nxt;
    y_r <= y_nxt;
    cx_r <= cx_nxt;
    cy_r <= cy_nxt;
    dx_r <= dx_nxt;
    dy_r <= dy_nxt;
    fresh_r <= fresh_nxt;
    ok_r <= ok_nxt;
    is_top_r <= is_top_nxt;
    out_label_r <= out_label_nxt;
    out_bar_r <= out_bar_nxt;
  end
endmodule

[test/tb_trapped_ball_region_fill.sv]
// Testbench for trapped_ball_region_fill: loads line-art areas, runs the fill
// and reads labels back against a built-in label predictor. Depends on tbrf_pkg.
module tb_trapped_ball_region_fill;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCH_LIMIT = 4000000;

  typedef struct {
    logic [12:0] label;
    logic        barrier;
    logic [12:0] count;
  } pix_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_req_type = tbrf_pkg::REQ_LOAD;
  logic [11:0] in_pixel_addr = '0;
  logic [7:0]  in_pixel_value = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [12:0] out_region_label;
  logic        out_is_barrier;
  logic [12:0] out_region_count;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = tbrf_pkg::CFG_RADIUS;
  logic [6:0]  cfg_data = '0;

  trapped_ball_region_fill uut (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // predictor state
  int          label_mem [tbrf_pkg::PIX_N];
  bit          barrier_mem [tbrf_pkg::PIX_N];
  bit          loaded [tbrf_pkg::PIX_N];
  int          walk_x [tbrf_pkg::PIX_N];
  int          walk_y [tbrf_pkg::PIX_N];
  int          walk_d [tbrf_pkg::PIX_N];
  int          walk_sp;
  int          next_label;
  int          radius_reg;
  int          width_reg;
  int          height_reg;
  int          loaded_addrs [$];
  pix_result_t expected_q [$];

  int  errors = 0;
  bit  idle_en = 1'b1;
  int  watch_cnt = 0;
  int  stall_cnt = 0;

  function automatic bit try_ball(int cx, int cy, int r, int aw, int ah, int lab);
    int  lim;
    int  p;
    bit  fresh;
    lim = (r + 1) * (r + 1);
    fresh = 1'b0;
    if (cx - r < 0 || cy - r < 0 || cx + r >= aw || cy + r >= ah) return 1'b0;
    for (int dy = -r; dy <= r; dy++)
      for (int dx = -r; dx <= r; dx++) begin
        if (dx * dx + dy * dy >= lim) continue;
        p = (cy + dy) * tbrf_pkg::IMG_W + cx + dx;
        if (barrier_mem[p]) return 1'b0;
        if (label_mem[p] == 0) fresh = 1'b1;
        else if (label_mem[p] != lab) return 1'b0;
      end
    if (!fresh) return 1'b0;
    for (int dy = -r; dy <= r; dy++)
      for (int dx = -r; dx <= r; dx++)
        if (dx * dx + dy * dy < lim) label_mem[(cy + dy) * tbrf_pkg::IMG_W + cx + dx] = lab;
    return 1'b1;
  endfunction

  function automatic void push_walk(int x, int y);
    if (walk_sp >= tbrf_pkg::PIX_N) return;
    walk_x[walk_sp] = x;
    walk_y[walk_sp] = y;
    walk_d[walk_sp] = 0;
    walk_sp++;
  endfunction

  function automatic void fill_regions();
    int r, aw, ah, p, t, nx, ny, d;
    r  = radius_reg > tbrf_pkg::MAX_R ? tbrf_pkg::MAX_R : radius_reg;
    aw = width_reg > tbrf_pkg::IMG_W ? tbrf_pkg::IMG_W : width_reg;
    ah = height_reg > tbrf_pkg::IMG_H ? tbrf_pkg::IMG_H : height_reg;
    if (r < 2) return;
    for (int y = 0; y < ah; y++)
      for (int x = 0; x < aw; x++) begin
        p = y * tbrf_pkg::IMG_W + x;
        if (label_mem[p] != 0 || barrier_mem[p]) continue;
        if (next_label >= tbrf_pkg::LABEL_LIM) return;
        if (!try_ball(x, y, r, aw, ah, next_label)) continue;
        walk_sp = 0;
        push_walk(x, y);
        while (walk_sp > 0) begin
          t = walk_sp - 1;
          nx = walk_x[t];
          ny = walk_y[t];
          d = walk_d[t];
          if (d >= 4) begin
            walk_sp--;
            continue;
          end
          walk_d[t] = d + 1;
          case (d)
            0: nx += tbrf_pkg::WALK_STEP;
            1: nx -= tbrf_pkg::WALK_STEP;
            2: ny += tbrf_pkg::WALK_STEP;
            default: ny -= tbrf_pkg::WALK_STEP;
          endcase
          if (try_ball(nx, ny, r, aw, ah, next_label)) push_walk(nx, ny);
        end
        next_label++;
      end
  endfunction

  function automatic pix_result_t predict_pixel(logic [1:0] req, int addr, int val);
    pix_result_t res;
    res.label = '0;
    res.barrier = 1'b0;
    if (req == tbrf_pkg::REQ_LOAD) begin
      barrier_mem[addr] = (val != 0);
      label_mem[addr] = 0;
      if (!loaded[addr]) loaded_addrs.insert(loaded_addrs.size(), addr);
      loaded[addr] = 1'b1;
    end else if (req == tbrf_pkg::REQ_RUN) begin
      fill_regions();
    end else if (req == tbrf_pkg::REQ_READ) begin
      res.barrier = barrier_mem[addr];
      res.label = barrier_mem[addr] ? 13'd0 : 13'(label_mem[addr]);
    end
    res.count = 13'(next_label - 1);
    return res;
  endfunction

  always @(posedge clk) begin
    if (rst_n) begin
      if (stall_cnt > 0) begin
        out_ready <= 1'b0;
        stall_cnt <= stall_cnt - 1;
      end else if (idle_en && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        stall_cnt <= $urandom_range(0, 3);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    pix_result_t exp_res;
    if (rst_n && out_valid && out_ready) begin
      if (expected_q.size() == 0) begin
        $error("unexpected result transfer: label %0d", out_region_label);
        errors++;
      end else begin
        exp_res = expected_q.pop_front();
        if (out_region_label !== exp_res.label) begin
          $error("region_label expected %0d actual %0d", exp_res.label, out_region_label);
          errors++;
        end
        if (out_is_barrier !== exp_res.barrier) begin
          $error("is_barrier expected %0d actual %0d", exp_res.barrier, out_is_barrier);
          errors++;
        end
        if (out_region_count !== exp_res.count) begin
          $error("region_count expected %0d actual %0d", exp_res.count, out_region_count);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) watch_cnt <= 0;
    else watch_cnt <= watch_cnt + 1;
    if (watch_cnt > WATCH_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic send_item(logic [1:0] req, int addr, int val);
    if (idle_en && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req_type <= req;
    in_pixel_addr <= 12'(addr);
    in_pixel_value <= 8'(val);
    do @(posedge clk); while (!(in_valid && in_ready));
    expected_q.insert(expected_q.size(), predict_pixel(req, addr, val));
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, int val);
    drain();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= 7'(val);
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      tbrf_pkg::CFG_RADIUS: radius_reg = val & 15;
      tbrf_pkg::CFG_WIDTH:  width_reg = val & 127;
      default:              height_reg = val & 127;
    endcase
  endtask

  task automatic set_area(int r, int w, int h);
    write_reg(tbrf_pkg::CFG_RADIUS, r);
    write_reg(tbrf_pkg::CFG_WIDTH, w);
    write_reg(tbrf_pkg::CFG_HEIGHT, h);
  endtask

  task automatic read_random();
    send_item(tbrf_pkg::REQ_READ, loaded_addrs[$urandom_range(0, loaded_addrs.size() - 1)],
              $urandom_range(0, 255));
  endtask

  task automatic test_directed();
    set_area(4, 0, 64);
    send_item(tbrf_pkg::REQ_LOAD, 0, 0);
    send_item(tbrf_pkg::REQ_LOAD, 4095, 255);
    send_item(tbrf_pkg::REQ_LOAD, 12'hAAA, 8'h55);
    send_item(tbrf_pkg::REQ_LOAD, 12'h555, 8'hAA);
    send_item(tbrf_pkg::REQ_LOAD, 12'hFFE, 1);
    send_item(tbrf_pkg::REQ_LOAD, 12'h001, 8'h80);
    send_item(tbrf_pkg::REQ_READ, 0, 0);
    send_item(tbrf_pkg::REQ_READ, 4095, 0);
    send_item(tbrf_pkg::REQ_READ, 12'hAAA, 255);
    send_item(tbrf_pkg::REQ_READ, 12'h555, 0);
    send_item(tbrf_pkg::REQ_READ, 12'hFFE, 0);
    send_item(tbrf_pkg::REQ_READ, 12'h001, 0);
    send_item(tbrf_pkg::REQ_NOP, 4095, 255);
    send_item(tbrf_pkg::REQ_RUN, 0, 0);
    send_item(tbrf_pkg::REQ_LOAD, 4095, 0);
    send_item(tbrf_pkg::REQ_READ, 4095, 0);
    send_item(tbrf_pkg::REQ_NOP, 0, 0);
  endtask

  // Load an active area with line art, fill it and poke at it.
  task automatic test_fill_session(int r, int w, int h, int ops, bit hold_off);
    int we, he, vx, hy, val, y, x;
    set_area(r, w, h);
    we = width_reg > tbrf_pkg::IMG_W ? tbrf_pkg::IMG_W : width_reg;
    he = height_reg > tbrf_pkg::IMG_H ? tbrf_pkg::IMG_H : height_reg;
    vx = $urandom_range(0, we + 3);
    hy = $urandom_range(0, he + 3);
    for (int p = 0; p < we * he; p++) begin
      y = p / we;
      x = p % we;
      if (x == vx || y == hy || $urandom_range(0, 39) == 0) val = $urandom_range(1, 255);
      else val = 0;
      send_item(tbrf_pkg::REQ_LOAD, y * tbrf_pkg::IMG_W + x, val);
    end
    if (hold_off) drain();
    send_item(tbrf_pkg::REQ_RUN, 0, 0);
    for (int i = 0; i < ops; i++) begin
      case ($urandom_range(0, 19))
        0, 1: begin
          if (we * he > 0) begin
            y = $urandom_range(0, he - 1);
            x = $urandom_range(0, we - 1);
            send_item(tbrf_pkg::REQ_LOAD, y * tbrf_pkg::IMG_W + x,
                      $urandom_range(0, 1) ? 0 : $urandom_range(0, 255));
          end
        end
        2: send_item(tbrf_pkg::REQ_RUN, 0, 0);
        3: send_item(tbrf_pkg::REQ_NOP, $urandom_range(0, 4095), $urandom_range(0, 255));
        default: read_random();
      endcase
    end
    send_item(tbrf_pkg::REQ_RUN, 0, 0);
  endtask

  initial begin
    foreach (label_mem[i]) begin
      label_mem[i] = 0;
      barrier_mem[i] = 1'b0;
      loaded[i] = 1'b0;
    end
    walk_sp = 0;
    next_label = 1;
    radius_reg = 4;
    width_reg = 64;
    height_reg = 64;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_fill_session(2, 12, 10, 60, 1'b0);
    test_fill_session(15, 18, 18, 60, 1'b1);
    test_fill_session(3, 127, 2, 60, 1'b0);
    test_fill_session(2, 2, 127, 60, 1'b0);
    test_fill_session(1, 8, 8, 40, 1'b0);
    test_fill_session(0, 1, 64, 40, 1'b0);
    test_fill_session(5, 14, 14, 60, 1'b0);
    idle_en = 1'b0;
    test_fill_session(4, 12, 12, 80, 1'b0);

    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end
endmodule
